// ===== hdl/lcd_pkg.sv =====
// lcd_pkg: shared types, command codes and the power-up byte table
// for the lcd command byte stream block; no dependencies
`default_nettype none

package lcd_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_INIT   = 2'd0,
    KIND_WINDOW = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // controller command codes used by the window sequence
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // bytes emitted per item kind
  localparam int INIT_LEN = 60;
  localparam int WIN_LEN  = 11;
  localparam int PIX_LEN  = 2;

  // queue between the front and back parts
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  // classified item: window carries col_s, col_e, row_s, row_e in w0..w3,
  // pixel carries its color in w0
  typedef struct packed {
    kind_t       kind;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
  } item_t;

  // queue status toward both neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // power-up table entry: bit 8 set means data byte, clear means command
  function automatic logic [8:0] init_entry(input logic [5:0] idx);
    logic [8:0] e;
    case (idx)
      6'd0:  e = 9'h036;  6'd1:  e = 9'h100;
      6'd2:  e = 9'h03A;  6'd3:  e = 9'h105;
      6'd4:  e = 9'h0B2;  6'd5:  e = 9'h10C;  6'd6:  e = 9'h10C;
      6'd7:  e = 9'h100;  6'd8:  e = 9'h133;  6'd9:  e = 9'h133;
      6'd10: e = 9'h0B7;  6'd11: e = 9'h135;
      6'd12: e = 9'h0BB;  6'd13: e = 9'h119;
      6'd14: e = 9'h0C0;  6'd15: e = 9'h12C;
      6'd16: e = 9'h0C2;  6'd17: e = 9'h101;
      6'd18: e = 9'h0C3;  6'd19: e = 9'h112;
      6'd20: e = 9'h0C4;  6'd21: e = 9'h120;
      6'd22: e = 9'h0C6;  6'd23: e = 9'h10F;
      6'd24: e = 9'h0D0;  6'd25: e = 9'h1A4;  6'd26: e = 9'h1A1;
      6'd27: e = 9'h0E0;  6'd28: e = 9'h1D0;  6'd29: e = 9'h104;
      6'd30: e = 9'h10D;  6'd31: e = 9'h111;  6'd32: e = 9'h113;
      6'd33: e = 9'h12B;  6'd34: e = 9'h13F;  6'd35: e = 9'h154;
      6'd36: e = 9'h14C;  6'd37: e = 9'h118;  6'd38: e = 9'h10D;
      6'd39: e = 9'h10B;  6'd40: e = 9'h11F;  6'd41: e = 9'h123;
      6'd42: e = 9'h0E1;  6'd43: e = 9'h1D0;  6'd44: e = 9'h104;
      6'd45: e = 9'h10C;  6'd46: e = 9'h111;  6'd47: e = 9'h113;
      6'd48: e = 9'h12C;  6'd49: e = 9'h13F;  6'd50: e = 9'h144;
      6'd51: e = 9'h151;  6'd52: e = 9'h12F;  6'd53: e = 9'h11F;
      6'd54: e = 9'h11F;  6'd55: e = 9'h120;  6'd56: e = 9'h123;
      6'd57: e = 9'h021;  6'd58: e = 9'h011;  6'd59: e = 9'h029;
      default: e = 9'h000;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lcd_ifs.sv =====
// lcd_in_if, lcd_out_if: valid/ready channels for requests and output bytes
// no dependencies
`default_nettype none

interface lcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] start_index;
  logic [15:0] pixel_count;
  logic [15:0] pixel;

  modport source (output valid, kind, start_index, pixel_count, pixel, input ready);
  modport sink (input valid, kind, start_index, pixel_count, pixel, output ready);
endinterface

interface lcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/lcd_command_byte_stream.sv =====
// lcd_command_byte_stream: one output byte per cycle while the output is not stalled;
// a pixel item is 2 bytes, a window item 11 and an init item 60.
// A pixel or init item is pushed to the queue on acceptance; a window item first passes
// a multiply/remainder pass for its start index, another for its end index and a push state;
// input waits while a window is being computed and while the 4-entry queue is full.
// Reset (synchronous, rst_n low) empties the queue and the output stage.
`default_nettype none

module lcd_command_byte_stream #(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 240
) (
  input  wire          clk,
  input  wire          rst_n,
  lcd_in_if.sink       in_chan,
  lcd_out_if.source    out_chan
);

  lcd_pkg::q_stat_t  q_stat;
  lcd_pkg::item_t    push_item;
  lcd_pkg::item_t    head;
  logic              push;
  logic              pop;

  // request side: accept, classify, compute window bounds
  lcd_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  lcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  // byte side: sequence bytes into the output register
  lcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("queue written while full");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("queue read while empty");

  // output stage is empty right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

// ===== hdl/lcd_front.sv =====
// lcd_front: accepts requests, turns window bounds into column/row with a
// reciprocal multiply and pushes classified items; depends on lcd_pkg, lcd_ifs
`default_nettype none

module lcd_front #(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 240
) (
  input  wire                   clk,
  input  wire                   rst_n,
  lcd_in_if.sink                in_chan,
  input  wire lcd_pkg::q_stat_t q_stat,
  output logic                  push,
  output lcd_pkg::item_t        push_item
);

  // index / PANEL_WIDTH as (index * RECIP) >> SH, exact for 17-bit indexes
  localparam int NUMW = 17;
  localparam int MW   = 18;
  localparam int PW   = NUMW + MW;
  localparam int SH   = NUMW + $clog2(PANEL_WIDTH);
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(PANEL_WIDTH) - 64'd1) / 64'(PANEL_WIDTH);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_S,
    F_REM_S,
    F_MUL_E,
    F_REM_E,
    F_PUSH
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [NUMW-1:0]  num_r, num_nxt;
  logic [NUMW-1:0]  end_r, end_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [15:0]      col_s_r, col_s_nxt;
  logic [15:0]      row_s_r, row_s_nxt;
  logic [15:0]      col_e_r, col_e_nxt;
  logic [15:0]      row_e_r, row_e_nxt;

  logic [NUMW-1:0]  quo_c;
  logic [NUMW-1:0]  rem_c;
  logic [15:0]      row_c;
  logic [15:0]      cnt_fix;
  logic [NUMW-1:0]  end_idx;
  logic             accept;

  // quotient, remainder and clamped row from the registered product
  always_comb begin
    quo_c = NUMW'(prod_r >> SH);
    rem_c = num_r - NUMW'(quo_c * NUMW'(PANEL_WIDTH));
    if (quo_c > NUMW'(PANEL_HEIGHT - 1)) begin
      row_c = 16'(PANEL_HEIGHT - 1);
    end else begin
      row_c = quo_c[15:0];
    end
  end

  // end index, a zero count counts as one
  always_comb begin
    cnt_fix = (in_chan.pixel_count == 16'd0) ? 16'd1 : in_chan.pixel_count;
    end_idx = {1'b0, in_chan.start_index} + {1'b0, cnt_fix} - 17'd1;
  end

  assign in_chan.ready = (state_r == F_IDLE) && !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  // next state, bound computation and queue push
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    end_nxt   = end_r;
    prod_nxt  = prod_r;
    col_s_nxt = col_s_r;
    row_s_nxt = row_s_r;
    col_e_nxt = col_e_r;
    row_e_nxt = row_e_r;
    push      = 1'b0;
    push_item = '{kind: lcd_pkg::kind_t'(in_chan.kind), w0: in_chan.pixel,
                  w1: 16'd0, w2: 16'd0, w3: 16'd0};
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          unique case (lcd_pkg::kind_t'(in_chan.kind)) inside
            lcd_pkg::KIND_INIT, lcd_pkg::KIND_PIXEL: begin
              push = 1'b1;
            end
            lcd_pkg::KIND_WINDOW: begin
              num_nxt   = {1'b0, in_chan.start_index};
              end_nxt   = end_idx;
              state_nxt = F_MUL_S;
            end
            default: ;
          endcase
        end
      end
      F_MUL_S: begin
        prod_nxt  = PW'(num_r) * PW'(RECIP);
        state_nxt = F_REM_S;
      end
      F_REM_S: begin
        // capture start bounds and load the end index
        col_s_nxt = 16'(rem_c);
        row_s_nxt = row_c;
        num_nxt   = end_r;
        state_nxt = F_MUL_E;
      end
      F_MUL_E: begin
        prod_nxt  = PW'(num_r) * PW'(RECIP);
        state_nxt = F_REM_E;
      end
      F_REM_E: begin
        col_e_nxt = 16'(rem_c);
        row_e_nxt = row_c;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        push_item = '{kind: lcd_pkg::KIND_WINDOW, w0: col_s_r, w1: col_e_r,
                      w2: row_s_r, w3: row_e_r};
        if (!q_stat.full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // state and bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    num_r   <= num_nxt;
    end_r   <= end_nxt;
    prod_r  <= prod_nxt;
    col_s_r <= col_s_nxt;
    row_s_r <= row_s_nxt;
    col_e_r <= col_e_nxt;
    row_e_r <= row_e_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/lcd_queue.sv =====
// lcd_queue: small register queue of classified items between front and back
// depends on lcd_pkg
`default_nettype none

module lcd_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire lcd_pkg::item_t  push_item,
  input  wire                  pop,
  output lcd_pkg::q_stat_t     q_stat,
  output lcd_pkg::item_t       head
);

  localparam int QD  = lcd_pkg::QDEPTH;
  localparam int QPW = lcd_pkg::QPW;

  lcd_pkg::item_t    mem_r [QD];
  logic [QPW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QPW:0]      count_r;

  assign q_stat.full  = (count_r == (QPW+1)'(QD));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPW+1)'(1);
        2'b01:   count_r <= count_r - (QPW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcd_back.sv =====
// lcd_back: walks the head item byte by byte into a registered output stage
// depends on lcd_pkg, lcd_ifs
`default_nettype none

module lcd_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire lcd_pkg::q_stat_t q_stat,
  input  wire lcd_pkg::item_t   head,
  output logic                  pop,
  lcd_out_if.source             out_chan
);

  // window byte positions that carry commands
  localparam logic [5:0] WS_CASET = 6'd0;
  localparam logic [5:0] WS_RASET = 6'd5;
  localparam logic [5:0] WS_RAMWR = 6'd10;

  logic [5:0]  step_r, step_nxt;
  logic        valid_r;
  logic [7:0]  byte_r;
  logic        data_r;
  logic        last_r;

  logic        load;
  logic [7:0]  byte_c;
  logic        data_c;
  logic        last_c;
  logic [15:0] word_c;
  logic        hi_c;
  logic [8:0]  ent;

  assign load = !q_stat.empty && (!valid_r || out_chan.ready);
  assign ent  = lcd_pkg::init_entry(step_r);

  // pick the 16-bit bound for the current window byte
  always_comb begin
    case (step_r) inside
      6'd1, 6'd2: word_c = head.w0;
      6'd3, 6'd4: word_c = head.w1;
      6'd6, 6'd7: word_c = head.w2;
      default:    word_c = head.w3;
    endcase
  end

  // first byte of each bound is its high byte
  assign hi_c = (step_r == 6'd1) || (step_r == 6'd3) || (step_r == 6'd6) ||
                (step_r == 6'd8);

  // byte decoder per item kind
  always_comb begin
    byte_c = 8'h00;
    data_c = 1'b1;
    last_c = 1'b0;
    unique case (head.kind)
      lcd_pkg::KIND_INIT: begin
        byte_c = ent[7:0];
        data_c = ent[8];
        last_c = (step_r == 6'(lcd_pkg::INIT_LEN - 1));
      end
      lcd_pkg::KIND_WINDOW: begin
        last_c = (step_r == 6'(lcd_pkg::WIN_LEN - 1));
        if (step_r == WS_CASET) begin
          byte_c = lcd_pkg::CMD_CASET;
          data_c = 1'b0;
        end else if (step_r == WS_RASET) begin
          byte_c = lcd_pkg::CMD_RASET;
          data_c = 1'b0;
        end else if (step_r == WS_RAMWR) begin
          byte_c = lcd_pkg::CMD_RAMWR;
          data_c = 1'b0;
        end else begin
          byte_c = hi_c ? word_c[15:8] : word_c[7:0];
        end
      end
      lcd_pkg::KIND_PIXEL: begin
        byte_c = (step_r == 6'd0) ? head.w0[15:8] : head.w0[7:0];
        last_c = (step_r == 6'(lcd_pkg::PIX_LEN - 1));
      end
      default: begin
        last_c = 1'b1;
      end
    endcase
  end

  assign pop      = load && last_c;
  assign step_nxt = pop ? 6'd0 : (load ? step_r + 6'd1 : step_r);

  assign out_chan.valid    = valid_r;
  assign out_chan.out_byte = byte_r;
  assign out_chan.is_data  = data_r;
  assign out_chan.last     = last_r;

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 6'd0;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_c;
      data_r <= data_c;
      last_r <= last_c;
    end
  end

endmodule

`default_nettype wire
